// ===== design/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded deque package
// Request codes, controller states and fixed field widths shared by the
// deque core.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned FuncWidth  = 3;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 5;

  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 72;

  // Reported for both ends while the queue holds nothing.
  localparam logic [ValueWidth-1:0] EmptyMark = 32'h8000_0000;

  typedef enum logic [FuncWidth-1:0] {
    FN_PUSH_REAR  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_REAR   = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_CLEAR      = 3'd4,
    FN_QUERY      = 3'd5
  } bdq_func_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } bdq_state_e;

endpackage

// ===== design/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// Bounded deque storage RAM
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bounded_deque_core.sv =====
// ----------------------------------------------------------------------------
// Bounded deque core
// Double-ended queue of signed 32-bit values kept in a ring of DEPTH RAM
// entries, with push and pop at both ends, clear and query requests.
// ----------------------------------------------------------------------------
// Each request has a request step and a response step: in the request step
// the pointers and count are updated, a pushed value is written to the RAM
// and both ends are read at their new addresses; in the response step, once
// the output register is free or draining, the registered read data is
// collected into it. The core takes a new request only after that collection,
// but while the previous result still waits in the output register. An empty
// queue reports 0x80000000 at both ends, and a push on a full queue is dropped
// and flagged. The reported count is the low five bits of the entry count.
// ----------------------------------------------------------------------------
module bounded_deque_core
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [2:0] func, [34:3] value, [39:35] zero
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [31:0] front_value, [63:32] rear_value, [68:64] count, [69] is_empty,
  // [70] push_dropped, [71] zero
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  bdq_state_e state_q, state_d;

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  logic                  accept;
  logic                  resp_load;
  logic [FuncWidth-1:0]  in_func;
  logic [ValueWidth-1:0] in_value;

  logic          is_full;
  logic          is_zero;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          drop;
  logic [AW-1:0] rd_front_addr, rd_rear_addr;

  logic [ValueWidth-1:0] front_rdata, rear_rdata;

  logic                  fwd_front_q, fwd_rear_q;
  logic [ValueWidth-1:0] wval_q;
  logic                  drop_q;

  logic                  out_valid_q;
  logic [ValueWidth-1:0] out_front_q, out_rear_q;
  logic [CountWidth-1:0] out_count_q;
  logic                  out_empty_q;
  logic                  out_drop_q;

  logic [ValueWidth-1:0] front_val, rear_val;
  logic [CW+CountWidth-1:0] count_wide;

  assign in_func  = s_axis_tdata[FuncWidth-1:0];
  assign in_value = s_axis_tdata[FuncWidth+ValueWidth-1:FuncWidth];
  assign accept   = s_axis_tvalid & s_axis_tready;

  assign is_full = (count_q == FullCnt);
  assign is_zero = (count_q == '0);

  assign head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign tail_inc = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? LastIdx : tail_q - 1'b1;

  // Pointer, count and write-port update for the incoming request.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = tail_q;
    drop    = 1'b0;
    case (in_func)
      FN_PUSH_REAR: begin
        if (is_full) begin
          drop = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = tail_q;
          tail_d  = tail_inc;
          count_d = count_q + 1'b1;
        end
      end
      FN_PUSH_FRONT: begin
        if (is_full) begin
          drop = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = head_dec;
          head_d  = head_dec;
          count_d = count_q + 1'b1;
        end
      end
      FN_POP_REAR: begin
        if (!is_zero) begin
          tail_d  = tail_dec;
          count_d = count_q - 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (!is_zero) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
        end
      end
      FN_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Both ends are read at their post-request addresses. While a result waits
  // for the output register, the stored pointers are read again so that the
  // read data stays on the same entries.
  assign rd_front_addr = accept ? head_d : head_q;
  assign rd_rear_addr  = accept ? ((tail_d == '0) ? LastIdx : tail_d - 1'b1) : tail_dec;

  // Two copies of the ring give one read port for each end.
  bdq_ram #(
    .Width (ValueWidth),
    .Depth (DEPTH)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (accept & wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_value),
    .raddr_i (rd_front_addr),
    .rdata_o (front_rdata)
  );

  bdq_ram #(
    .Width (ValueWidth),
    .Depth (DEPTH)
  ) u_rear_ram (
    .clk_i   (clk_i),
    .we_i    (accept & wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_value),
    .raddr_i (rd_rear_addr),
    .rdata_o (rear_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (resp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    resp_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_RESP: begin
        resp_load = !out_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
    end
  end

  // The RAM read coincides with the write, so a freshly pushed value is
  // forwarded rather than taken from the read port.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_front_q <= wr_en && (wr_addr == rd_front_addr);
      fwd_rear_q  <= wr_en && (wr_addr == rd_rear_addr);
      wval_q      <= in_value;
      drop_q      <= drop;
    end
  end

  assign front_val  = is_zero ? EmptyMark : (fwd_front_q ? wval_q : front_rdata);
  assign rear_val   = is_zero ? EmptyMark : (fwd_rear_q ? wval_q : rear_rdata);
  assign count_wide = (CW + CountWidth)'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      out_front_q <= front_val;
      out_rear_q  <= rear_val;
      out_count_q <= count_wide[CountWidth-1:0];
      out_empty_q <= is_zero;
      out_drop_q  <= drop_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_drop_q, out_empty_q, out_count_q, out_rear_q,
                          out_front_q};

  // The entry count never passes the ring size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCnt)
    else $error("deque count exceeds DEPTH");

  // Every accepted request is followed by a response cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RESP))
    else $error("accepted request did not move to the response state");

  // A refused push only ever happens on a full, hence non-empty, queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_drop_q) |-> !out_empty_q)
    else $error("dropped push reported on an empty queue");

  // An empty result carries a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> (out_count_q == '0))
    else $error("empty result with non-zero count");

  // A result is loaded only when the output register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_load |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten while stalled");

endmodule

// ===== sim/deque_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque response checker
// Watches the request and response streams of the deque core. It keeps its
// own copy of the ring, the end pointers and the entry count. Each accepted
// request produces an expected response, and each accepted response is
// compared field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module deque_response_checker
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  input  logic                    req_ready_i,
  // [2:0] func, [34:3] value, [39:35] zero
  input  logic [InDataWidth-1:0]  req_data_i,
  input  logic                    rsp_valid_i,
  input  logic                    rsp_ready_i,
  // [31:0] front_value, [63:32] rear_value, [68:64] count, [69] is_empty,
  // [70] push_dropped, [71] zero
  input  logic [OutDataWidth-1:0] rsp_data_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  // Declared from the top field down, so that front_value lands in the lowest bits.
  typedef struct packed {
    logic                  push_dropped;
    logic                  is_empty;
    logic [CountWidth-1:0] count;
    logic [ValueWidth-1:0] rear_value;
    logic [ValueWidth-1:0] front_value;
  } deque_rsp_t;

  logic [ValueWidth-1:0] ring_mem [DEPTH];
  int unsigned           head_idx;
  int unsigned           tail_idx;
  int unsigned           live_count;
  deque_rsp_t            expected_responses [$];
  deque_rsp_t            got_rsp;
  deque_rsp_t            want_rsp;

  function automatic int unsigned wrap_inc(input int unsigned idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned wrap_dec(input int unsigned idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  task automatic report_mismatch(input string what, input logic [ValueWidth-1:0] want_v,
                                 input logic [ValueWidth-1:0] got_v);
    fail_count_o++;
    $display("[%0t] %s: expected %h, got %h", $time, what, want_v, got_v);
  endtask

  task automatic predict_response(input logic [FuncWidth-1:0] func,
                                  input logic [ValueWidth-1:0] value);
    deque_rsp_t rsp;
    rsp = '0;
    case (func)
      FN_PUSH_REAR: begin
        if (live_count >= DEPTH) begin
          rsp.push_dropped = 1'b1;
        end else begin
          ring_mem[tail_idx] = value;
          tail_idx = wrap_inc(tail_idx);
          live_count++;
        end
      end
      FN_PUSH_FRONT: begin
        if (live_count >= DEPTH) begin
          rsp.push_dropped = 1'b1;
        end else begin
          head_idx = wrap_dec(head_idx);
          ring_mem[head_idx] = value;
          live_count++;
        end
      end
      FN_POP_REAR: begin
        if (live_count > 0) begin
          tail_idx = wrap_dec(tail_idx);
          live_count--;
        end
      end
      FN_POP_FRONT: begin
        if (live_count > 0) begin
          head_idx = wrap_inc(head_idx);
          live_count--;
        end
      end
      FN_CLEAR: begin
        head_idx   = 0;
        tail_idx   = 0;
        live_count = 0;
      end
      // Query and the two spare codes leave the queue untouched.
      default: ;
    endcase
    if (live_count == 0) begin
      rsp.front_value = EmptyMark;
      rsp.rear_value  = EmptyMark;
      rsp.is_empty    = 1'b1;
    end else begin
      rsp.front_value = ring_mem[head_idx];
      rsp.rear_value  = ring_mem[wrap_dec(tail_idx)];
    end
    rsp.count = CountWidth'(live_count);
    expected_responses.push_back(rsp);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      head_idx     = 0;
      tail_idx     = 0;
      live_count   = 0;
      fail_count_o = 0;
      expected_responses.delete();
    end else begin
      // Responses are checked before the request of the same edge is predicted.
      if (rsp_valid_i && rsp_ready_i) begin
        got_rsp = deque_rsp_t'(rsp_data_i[$bits(deque_rsp_t)-1:0]);
        if (expected_responses.size() == 0) begin
          report_mismatch("response with nothing outstanding", '0, got_rsp.front_value);
        end else begin
          want_rsp = expected_responses.pop_front();
          if (got_rsp.front_value !== want_rsp.front_value)
            report_mismatch("front_value", want_rsp.front_value, got_rsp.front_value);
          if (got_rsp.rear_value !== want_rsp.rear_value)
            report_mismatch("rear_value", want_rsp.rear_value, got_rsp.rear_value);
          if (got_rsp.count !== want_rsp.count)
            report_mismatch("count", ValueWidth'(want_rsp.count), ValueWidth'(got_rsp.count));
          if (got_rsp.is_empty !== want_rsp.is_empty)
            report_mismatch("is_empty", ValueWidth'(want_rsp.is_empty),
                            ValueWidth'(got_rsp.is_empty));
          if (got_rsp.push_dropped !== want_rsp.push_dropped)
            report_mismatch("push_dropped", ValueWidth'(want_rsp.push_dropped),
                            ValueWidth'(got_rsp.push_dropped));
        end
      end
      if (req_valid_i && req_ready_i) begin
        predict_response(req_data_i[FuncWidth-1:0], req_data_i[FuncWidth +: ValueWidth]);
      end
    end
    pending_o <= expected_responses.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque testbench
// Drives a short directed sequence and then phases of fill, drain and mixed
// random traffic into the deque core, with random gaps on the request stream
// and back-pressure on the response stream. A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
  import bdq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RandomItems  = 850;
  localparam int unsigned IdlePercent  = 15;
  localparam int unsigned SteadyFirst  = 400;
  localparam int unsigned SteadyLast   = 550;
  localparam logic [FuncWidth-1:0] FnSpareHi = 3'd7;
  localparam logic [ValueWidth-1:0] IntMax   = 32'h7fff_ffff;
  localparam logic [ValueWidth-1:0] IntMin   = 32'h8000_0000;
  localparam logic [ValueWidth-1:0] AllOnes  = 32'hffff_ffff;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } traffic_mode_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    steady;
  int unsigned             fail_count;
  int unsigned             pending;
  int unsigned             sent;
  int unsigned             phase_len;
  traffic_mode_e           mode;

  bounded_deque_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  deque_response_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Response side back-pressure, switched off during the steady stretch.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // Holds one request until its transaction completes, after an optional gap.
  task automatic issue_request(input logic [FuncWidth-1:0] func,
                               input logic [ValueWidth-1:0] value);
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataWidth - FuncWidth - ValueWidth){1'b0}}, value, func};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [FuncWidth-1:0] draw_func(input traffic_mode_e m);
    int unsigned r;
    int unsigned push_pct;
    int unsigned pop_pct;
    r = $urandom_range(0, 99);
    case (m)
      MODE_FILL:  begin push_pct = 80; pop_pct = 12; end
      MODE_DRAIN: begin push_pct = 12; pop_pct = 80; end
      default:    begin push_pct = 38; pop_pct = 38; end
    endcase
    if (r < push_pct)
      return ($urandom_range(0, 1) != 0) ? FN_PUSH_FRONT : FN_PUSH_REAR;
    if (r < push_pct + pop_pct)
      return ($urandom_range(0, 1) != 0) ? FN_POP_FRONT : FN_POP_REAR;
    if (r < push_pct + pop_pct + 3)
      return FN_CLEAR;
    // Query and the spare codes that behave as a query.
    return FuncWidth'($urandom_range(FN_QUERY, FnSpareHi));
  endfunction

  function automatic logic [ValueWidth-1:0] draw_value();
    case ($urandom_range(0, 19))
      0:       return IntMin;
      1:       return IntMax;
      2:       return '0;
      3:       return AllOnes;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    steady        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Pops and queries on an empty queue, spare codes included.
    issue_request(FN_POP_REAR, 32'h1111_1111);
    issue_request(FN_POP_FRONT, 32'h2222_2222);
    issue_request(FN_QUERY, AllOnes);
    issue_request(FuncWidth'(FN_QUERY + 1), '0);
    issue_request(FnSpareHi, IntMax);
    // Extreme values at both ends; a stored minimum must not read as empty.
    issue_request(FN_PUSH_REAR, IntMax);
    issue_request(FN_PUSH_FRONT, IntMin);
    issue_request(FN_PUSH_REAR, '0);
    issue_request(FN_PUSH_FRONT, AllOnes);
    issue_request(FN_QUERY, '0);
    issue_request(FN_POP_REAR, '0);
    issue_request(FN_POP_FRONT, '0);
    issue_request(FN_POP_REAR, '0);
    issue_request(FN_POP_FRONT, '0);
    issue_request(FN_POP_FRONT, '0);
    issue_request(FN_PUSH_FRONT, 32'h5555_5555);
    issue_request(FN_PUSH_REAR, 32'haaaa_aaaa);
    issue_request(FN_CLEAR, AllOnes);
    issue_request(FN_QUERY, '0);
    // After a clear the front pointer wraps below slot zero.
    issue_request(FN_PUSH_FRONT, 32'h1234_5678);
    issue_request(FN_POP_REAR, '0);
    issue_request(FN_PUSH_REAR, 32'h0f0f_0f0f);

    sent = 0;
    while (sent < RandomItems) begin
      mode      = traffic_mode_e'($urandom_range(MODE_FILL, MODE_MIXED));
      phase_len = $urandom_range(20, 60);
      for (int unsigned i = 0; i < phase_len && sent < RandomItems; i++) begin
        steady = (sent >= SteadyFirst) && (sent < SteadyLast);
        issue_request(draw_func(mode), draw_value());
        sent++;
      end
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
